[design/tkpq_pkg.sv]
// Package for the two-key priority queue: sizes, opcodes, status codes,
// the stored entry layout and the compare result bundle.
// No dependencies.
package tkpq_pkg;

  localparam int CAPACITY   = 64;
  localparam int KEY_BITS   = 24;
  localparam int COORD_BITS = 16;
  localparam int IDX_BITS   = $clog2(CAPACITY);
  localparam int CNT_BITS   = $clog2(CAPACITY + 1);

  // operation codes
  localparam logic [2:0] FUNC_PUSH     = 3'd0;
  localparam logic [2:0] FUNC_POP      = 3'd1;
  localparam logic [2:0] FUNC_PEEK     = 3'd2;
  localparam logic [2:0] FUNC_CONTAINS = 3'd3;
  localparam logic [2:0] FUNC_REMOVE   = 3'd4;

  // result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_EMPTY    = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;
  localparam logic [1:0] STAT_NOTFOUND = 2'd3;

  // key value that stands for infinity; it is simply the largest key
  localparam logic [KEY_BITS-1:0] INFINITY = '1;

  typedef struct packed {
    logic [KEY_BITS-1:0]   kp;
    logic [KEY_BITS-1:0]   ks;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } entry_t;

  typedef struct packed {
    logic greater;    // stored key strictly greater than the new key
    logic pos_match;  // stored position equals the searched position
  } cmp_res_t;

endpackage

[design/tkpq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tkpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write one word, read one word per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[design/tkpq_cmp.sv]
// Shared compare unit: two-key order test and position match between
// the entry read from storage and the held operand. Uses tkpq_pkg.
module tkpq_cmp
  import tkpq_pkg::*;
(
  input  entry_t   stored,
  input  entry_t   operand,
  output cmp_res_t res
);

  // order on primary key, then on secondary key
  always_comb begin
    if (stored.kp != operand.kp) begin
      res.greater = stored.kp > operand.kp;
    end else begin
      res.greater = stored.ks > operand.ks;
    end
    res.pos_match = (stored.x == operand.x) && (stored.y == operand.y);
  end

endmodule

[design/two_key_priority_queue.sv]
// Two-key priority queue top level: sequencer over one entry RAM and one
// shared compare unit. Uses tkpq_pkg, tkpq_ram and tkpq_cmp.
//
//  channel  | handshake        | beat accepted when
//  ---------+------------------+------------------------------------
//  in_*     | start / busy     | start high and busy low at clk edge
//  out_*    | out_valid strobe | every edge ending an out_valid cycle
//
// An operation walks the sorted entries one per cycle through the single
// RAM read port before the one-cycle result strobe; peek reads only slot zero.
// Push into a full queue, pop or peek on an empty queue and unused codes
// strobe their result on the cycle after the beat. Synchronous active-low
// reset empties the queue; entry storage is not cleared. The receiver
// cannot stall: each result is shown for exactly one cycle.
module two_key_priority_queue
  import tkpq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            in_func,
  input  logic [KEY_BITS-1:0]   in_key_primary,
  input  logic [KEY_BITS-1:0]   in_key_secondary,
  input  logic [COORD_BITS-1:0] in_pos_x,
  input  logic [COORD_BITS-1:0] in_pos_y,
  output logic                  out_valid,
  output logic [1:0]            out_status,
  output logic                  out_found,
  output logic [KEY_BITS-1:0]   out_top_primary,
  output logic [KEY_BITS-1:0]   out_top_secondary,
  output logic [COORD_BITS-1:0] out_top_x,
  output logic [COORD_BITS-1:0] out_top_y,
  output logic [6:0]            out_occupancy
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  // control state
  logic                state_r, state_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [CNT_BITS-1:0] left_r, left_nxt;
  logic [IDX_BITS-1:0] rd_idx_r, rd_idx_nxt;
  logic                dvld_r, dvld_nxt;
  logic                stop_r, stop_nxt;
  logic                hit_r, hit_nxt;
  logic                out_valid_r, out_valid_nxt;

  // payload state
  logic [IDX_BITS-1:0] didx_r, didx_nxt;
  logic [2:0]          op_r, op_nxt;
  entry_t              ent_r, ent_nxt;
  entry_t              top_r, top_nxt;
  logic [1:0]          status_r, status_nxt;
  logic                found_r, found_nxt;

  // RAM and compare unit hookup
  logic                wr_en;
  logic [IDX_BITS-1:0] wr_addr;
  entry_t              wr_data;
  entry_t              rd_data;
  cmp_res_t            cmp;
  logic                match;
  logic                finish;

  tkpq_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_idx_r),
    .rd_data(rd_data)
  );

  tkpq_cmp u_cmp (
    .stored (rd_data),
    .operand(ent_r),
    .res    (cmp)
  );

  // pop and peek take slot zero; contains and remove match on position
  assign match = ((op_r == FUNC_POP) || (op_r == FUNC_PEEK)) ? (didx_r == '0)
                                                             : cmp.pos_match;
  assign finish = ((left_r == '0) || stop_r) && !dvld_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    left_nxt      = left_r;
    rd_idx_nxt    = rd_idx_r;
    dvld_nxt      = 1'b0;
    stop_nxt      = stop_r;
    hit_nxt       = hit_r;
    out_valid_nxt = 1'b0;
    didx_nxt      = didx_r;
    op_nxt        = op_r;
    ent_nxt       = ent_r;
    top_nxt       = top_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = ent_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt     = in_func;
          ent_nxt    = '{kp: in_key_primary, ks: in_key_secondary,
                         x: in_pos_x, y: in_pos_y};
          hit_nxt    = 1'b0;
          stop_nxt   = 1'b0;
          top_nxt    = '0;
          found_nxt  = 1'b0;
          status_nxt = STAT_OK;
          rd_idx_nxt = '0;
          left_nxt   = cnt_r;
          unique case (in_func)
            FUNC_PUSH: begin
              if (cnt_r == CNT_BITS'(CAPACITY)) begin
                status_nxt    = STAT_FULL;
                out_valid_nxt = 1'b1;
              end else begin
                // walk from the tail toward the head
                rd_idx_nxt = IDX_BITS'(cnt_r - CNT_BITS'(1));
                state_nxt  = ST_SCAN;
              end
            end
            FUNC_POP, FUNC_PEEK: begin
              if (cnt_r == '0) begin
                status_nxt    = STAT_EMPTY;
                out_valid_nxt = 1'b1;
              end else begin
                if (in_func == FUNC_PEEK) begin
                  left_nxt = CNT_BITS'(1);
                end
                state_nxt = ST_SCAN;
              end
            end
            FUNC_CONTAINS, FUNC_REMOVE: begin
              state_nxt = ST_SCAN;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // issue the next read
        if ((left_r != '0) && !stop_r) begin
          dvld_nxt   = 1'b1;
          didx_nxt   = rd_idx_r;
          left_nxt   = left_r - CNT_BITS'(1);
          rd_idx_nxt = (op_r == FUNC_PUSH) ? rd_idx_r - IDX_BITS'(1)
                                           : rd_idx_r + IDX_BITS'(1);
        end

        // handle the entry read last cycle
        if (dvld_r && !stop_r) begin
          if (op_r == FUNC_PUSH) begin
            wr_en   = 1'b1;
            wr_addr = didx_r + IDX_BITS'(1);
            if (cmp.greater) begin
              wr_data = rd_data;
            end else begin
              wr_data  = ent_r;
              stop_nxt = 1'b1;
            end
          end else if (hit_r) begin
            // close the gap left by the removed entry
            if ((op_r == FUNC_POP) || (op_r == FUNC_REMOVE)) begin
              wr_en   = 1'b1;
              wr_addr = didx_r - IDX_BITS'(1);
              wr_data = rd_data;
            end
          end else if (match) begin
            hit_nxt = 1'b1;
            if ((op_r == FUNC_POP) || (op_r == FUNC_PEEK)) begin
              top_nxt = rd_data;
            end
            if (op_r == FUNC_CONTAINS) begin
              stop_nxt = 1'b1;
            end
          end
        end

        // wrap up and strobe the result
        if (finish) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          unique case (op_r)
            FUNC_PUSH: begin
              if (!stop_r) begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = ent_r;
              end
              cnt_nxt = cnt_r + CNT_BITS'(1);
            end
            FUNC_POP: begin
              cnt_nxt = cnt_r - CNT_BITS'(1);
            end
            FUNC_CONTAINS: begin
              found_nxt = hit_r;
            end
            FUNC_REMOVE: begin
              if (hit_r) begin
                cnt_nxt = cnt_r - CNT_BITS'(1);
              end else begin
                status_nxt = STAT_NOTFOUND;
              end
            end
            default: begin
            end
          endcase
        end
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      left_r      <= '0;
      rd_idx_r    <= '0;
      dvld_r      <= 1'b0;
      stop_r      <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      left_r      <= left_nxt;
      rd_idx_r    <= rd_idx_nxt;
      dvld_r      <= dvld_nxt;
      stop_r      <= stop_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    didx_r   <= didx_nxt;
    op_r     <= op_nxt;
    ent_r    <= ent_nxt;
    top_r    <= top_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
  end

  // drive ports
  assign busy              = (state_r == ST_SCAN);
  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_found         = found_r;
  assign out_top_primary   = top_r.kp;
  assign out_top_secondary = top_r.ks;
  assign out_top_x         = top_r.x;
  assign out_top_y         = top_r.y;
  assign out_occupancy     = 7'(cnt_r);

  // fill count never passes capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_BITS'(CAPACITY))
    else $error("fill count above capacity");

  // a result strobe only ever follows the sequencer returning to idle
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE))
    else $error("result strobe while scanning");

  // every accepted beat either starts a scan or strobes a result
  a_beat_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted beat produced nothing");

  // storage is written only during a scan
  a_write_scan: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == ST_SCAN))
    else $error("RAM write outside a scan");

endmodule

[dv/tkpq_checker.sv]
`timescale 1ns / 1ps
// Checker for the two-key priority queue. It watches the command and result
// channels, keeps a sorted shadow copy of the queue and compares each result.
// Depends on tkpq_pkg.
module tkpq_checker
  import tkpq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic [2:0]            in_func,
  input  logic [KEY_BITS-1:0]   in_key_primary,
  input  logic [KEY_BITS-1:0]   in_key_secondary,
  input  logic [COORD_BITS-1:0] in_pos_x,
  input  logic [COORD_BITS-1:0] in_pos_y,
  input  logic                  out_valid,
  input  logic [1:0]            out_status,
  input  logic                  out_found,
  input  logic [KEY_BITS-1:0]   out_top_primary,
  input  logic [KEY_BITS-1:0]   out_top_secondary,
  input  logic [COORD_BITS-1:0] out_top_x,
  input  logic [COORD_BITS-1:0] out_top_y,
  input  logic [6:0]            out_occupancy,
  output int                    error_count,
  output int                    outstanding
);

  typedef struct packed {
    logic [1:0] status;
    logic       found;
    entry_t     top;
    logic [6:0] occupancy;
  } queue_result_t;

  entry_t        shadow_q [CAPACITY];
  int            fill_level = 0;
  queue_result_t awaited_results [$];
  queue_result_t oldest;
  entry_t        beat_item;
  int            mismatches = 0;

  // Return the first slot holding position (x, y), or fill_level if none.
  function automatic int find_position(input logic [COORD_BITS-1:0] x,
                                       input logic [COORD_BITS-1:0] y);
    for (int i = 0; i < fill_level; i++)
      if (shadow_q[i].x == x && shadow_q[i].y == y) return i;
    return fill_level;
  endfunction

  // Close the gap left by the entry at slot and shrink the queue.
  function automatic void drop_entry(input int slot);
    for (int i = slot; i + 1 < fill_level; i++) shadow_q[i] = shadow_q[i + 1];
    fill_level--;
  endfunction

  // Apply one command beat to the shadow queue and return its result.
  function automatic queue_result_t model_queue_op(input logic [2:0] func,
                                                   input entry_t item);
    queue_result_t res;
    int            slot;
    res  = '0;
    slot = 0;
    case (func)
      FUNC_PUSH: begin
        if (fill_level >= CAPACITY) begin
          res.status = STAT_FULL;
        end else begin
          // place after every entry whose key is not greater
          while (slot < fill_level &&
                 !({shadow_q[slot].kp, shadow_q[slot].ks} > {item.kp, item.ks}))
            slot++;
          for (int i = fill_level; i > slot; i--) shadow_q[i] = shadow_q[i - 1];
          shadow_q[slot] = item;
          fill_level++;
        end
      end
      FUNC_POP, FUNC_PEEK: begin
        if (fill_level == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          res.top = shadow_q[0];
          if (func == FUNC_POP) drop_entry(0);
        end
      end
      FUNC_CONTAINS: begin
        res.found = find_position(item.x, item.y) < fill_level;
      end
      FUNC_REMOVE: begin
        slot = find_position(item.x, item.y);
        if (slot < fill_level) drop_entry(slot);
        else res.status = STAT_NOTFOUND;
      end
      default: ;
    endcase
    res.occupancy = 7'(fill_level);
    return res;
  endfunction

  // Compare result beats first, then record the command beat of this edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      fill_level = 0;
      awaited_results.delete();
    end else begin
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result beat with no command awaiting it", $time);
          mismatches++;
        end else begin
          oldest = awaited_results.pop_front();
          if (out_status !== oldest.status || out_found !== oldest.found ||
              out_top_primary !== oldest.top.kp ||
              out_top_secondary !== oldest.top.ks ||
              out_top_x !== oldest.top.x || out_top_y !== oldest.top.y ||
              out_occupancy !== oldest.occupancy) begin
            if (mismatches < 10) begin
              $display("%0t: result mismatch: expected status %0d found %0d %s",
                       $time, oldest.status, oldest.found, "");
              $display("  expected top %h/%h (%0d,%0d) occ %0d",
                       oldest.top.kp, oldest.top.ks,
                       oldest.top.x, oldest.top.y, oldest.occupancy);
              $display("  got status %0d found %0d top %h/%h (%0d,%0d) occ %0d",
                       out_status, out_found, out_top_primary, out_top_secondary,
                       out_top_x, out_top_y, out_occupancy);
            end
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        beat_item.kp = in_key_primary;
        beat_item.ks = in_key_secondary;
        beat_item.x  = in_pos_x;
        beat_item.y  = in_pos_y;
        awaited_results.push_back(model_queue_op(in_func, beat_item));
      end
    end
    outstanding <= awaited_results.size();
    error_count <= mismatches;
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// Testbench top for two_key_priority_queue: makes command beats, hosts the
// checker beside the block and gives the verdict.
// Depends on tkpq_pkg, two_key_priority_queue and tkpq_checker.
module tb
  import tkpq_pkg::*;
();

  localparam logic [2:0] FUNC_UNUSED_LO = 3'd5;
  localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;
  localparam int         DRAIN_CYCLES   = CAPACITY + 16;
  localparam int         ROUNDS         = 4;
  localparam int         ROUND_ITEMS    = 120;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [2:0]            in_func = '0;
  logic [KEY_BITS-1:0]   in_key_primary = '0;
  logic [KEY_BITS-1:0]   in_key_secondary = '0;
  logic [COORD_BITS-1:0] in_pos_x = '0;
  logic [COORD_BITS-1:0] in_pos_y = '0;
  logic                  out_valid;
  logic [1:0]            out_status;
  logic                  out_found;
  logic [KEY_BITS-1:0]   out_top_primary;
  logic [KEY_BITS-1:0]   out_top_secondary;
  logic [COORD_BITS-1:0] out_top_x;
  logic [COORD_BITS-1:0] out_top_y;
  logic [6:0]            out_occupancy;
  int                    error_count;
  int                    outstanding;
  bit                    pauses_on = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  two_key_priority_queue dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_key_primary(in_key_primary),
    .in_key_secondary(in_key_secondary), .in_pos_x(in_pos_x), .in_pos_y(in_pos_y),
    .out_valid(out_valid), .out_status(out_status), .out_found(out_found),
    .out_top_primary(out_top_primary), .out_top_secondary(out_top_secondary),
    .out_top_x(out_top_x), .out_top_y(out_top_y), .out_occupancy(out_occupancy)
  );

  tkpq_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_key_primary(in_key_primary),
    .in_key_secondary(in_key_secondary), .in_pos_x(in_pos_x), .in_pos_y(in_pos_y),
    .out_valid(out_valid), .out_status(out_status), .out_found(out_found),
    .out_top_primary(out_top_primary), .out_top_secondary(out_top_secondary),
    .out_top_x(out_top_x), .out_top_y(out_top_y), .out_occupancy(out_occupancy),
    .error_count(error_count), .outstanding(outstanding)
  );

  // Drive one command beat, hold it until accepted, then maybe pause.
  task automatic issue(input logic [2:0] func, input logic [KEY_BITS-1:0] kp,
                       input logic [KEY_BITS-1:0] ks,
                       input logic [COORD_BITS-1:0] x,
                       input logic [COORD_BITS-1:0] y);
    int gap;
    start            <= 1'b1;
    in_func          <= func;
    in_key_primary   <= kp;
    in_key_secondary <= ks;
    in_pos_x         <= x;
    in_pos_y         <= y;
    do @(posedge clk); while (busy);
    if (pauses_on && $urandom_range(0, 9) < 3) begin
      // mostly short gaps, now and then a long one
      gap = ($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 40))
                                        : int'($urandom_range(1, 3));
      start            <= 1'b0;
      in_func          <= 3'($urandom);
      in_key_primary   <= KEY_BITS'($urandom);
      in_key_secondary <= KEY_BITS'($urandom);
      in_pos_x         <= COORD_BITS'($urandom);
      in_pos_y         <= COORD_BITS'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Favor a few small keys so that ties are common.
  function automatic logic [KEY_BITS-1:0] pick_key();
    logic [KEY_BITS-1:0] k;
    k = KEY_BITS'($urandom);
    case ($urandom_range(0, 9))
      0:          k = '0;
      1:          k = INFINITY;
      2, 3, 4, 5: k = KEY_BITS'($urandom_range(0, 3) * 256);
      default:    ;
    endcase
    return k;
  endfunction

  // Favor a small pool of positions so that searches hit.
  function automatic logic [COORD_BITS-1:0] pick_coord();
    logic [COORD_BITS-1:0] c;
    c = COORD_BITS'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5, 6: c = COORD_BITS'($urandom_range(0, 5));
      7:                   c = '1;
      default:             ;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] pick_func(input int push_pct);
    logic [2:0] f;
    if ($urandom_range(0, 99) < push_pct) return FUNC_PUSH;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5:    f = FUNC_POP;
      6, 7, 8:             f = FUNC_PEEK;
      9, 10, 11, 12, 13:   f = FUNC_CONTAINS;
      14, 15, 16, 17, 18:  f = FUNC_REMOVE;
      default:             f = 3'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
    endcase
    return f;
  endfunction

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // empty queue: pop, peek, remove and contains, then unused codes
    issue(FUNC_POP, '1, '1, '1, '1);
    issue(FUNC_PEEK, '0, '0, '0, '0);
    issue(FUNC_REMOVE, '0, '0, 16'd1, 16'd1);
    issue(FUNC_CONTAINS, '0, '0, 16'd1, 16'd1);
    issue(FUNC_UNUSED_LO, '1, '1, '1, '1);
    issue(FUNC_UNUSED_HI, '0, '0, '0, '0);

    // key extremes, ties on both keys, and secondary tie-break
    issue(FUNC_PUSH, INFINITY, INFINITY, '1, '1);
    issue(FUNC_PUSH, '0, '0, '0, '0);
    issue(FUNC_PUSH, 24'h000100, 24'h000200, 16'd3, 16'd4);
    issue(FUNC_PUSH, 24'h000100, 24'h000200, 16'd5, 16'd6);
    issue(FUNC_PUSH, 24'h000100, 24'h0001ff, 16'd7, 16'd8);
    issue(FUNC_PUSH, INFINITY, '0, 16'd9, 16'd9);
    issue(FUNC_PEEK, '0, '0, '0, '0);

    // search the last entry, miss, remove from the middle twice (the second misses) and the end
    issue(FUNC_CONTAINS, '0, '0, '1, '1);
    issue(FUNC_CONTAINS, '0, '0, 16'd5, 16'd5);
    issue(FUNC_REMOVE, '0, '0, 16'd3, 16'd4);
    issue(FUNC_REMOVE, '0, '0, 16'd3, 16'd4);
    issue(FUNC_REMOVE, '0, '0, '1, '1);

    // drain in key order and pop once more on empty
    repeat (5) issue(FUNC_POP, '0, '0, '0, '0);

    // alternate filling rounds (reach full) with draining rounds
    for (int round = 0; round < ROUNDS; round++) begin
      for (int n = 0; n < ROUND_ITEMS; n++) begin
        if (n % 32 == 0) pauses_on = ($urandom_range(0, 3) != 0);
        issue(pick_func((round % 2 == 0) ? 85 : 25), pick_key(), pick_key(),
              pick_coord(), pick_coord());
      end
    end

    // let the last results arrive, then settle
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
